@@ hw/rtl/plvm_pkg.sv @@
// Shared types and constants for the piecewise-linear level mapper.
// Holds the curve point layout, the divider step record and the reset curve.
// No dependencies; every other file in hw/rtl refers to it by scoped name.
`timescale 1ns / 1ps

package plvm_pkg;

    // Field widths.
    localparam int MvW       = 16;
    localparam int LvlW      = 14;
    localparam int ProdW     = MvW + LvlW;
    localparam int NumPoints = 4;
    localparam int PointIdxW = 2;

    // The quotient is never larger than the level difference, so one
    // division cell per level bit is enough.
    localparam int DivSteps = LvlW;

    // Stream and configuration port widths.
    localparam int InDataW   = 16;
    localparam int OutDataW  = 16;
    localparam int CfgIdxW   = 4;
    localparam int CfgDataW  = 16;

    // Register map: even index is a point voltage, odd index its level.
    localparam logic [CfgIdxW-1:0] CfgRegCount = CfgIdxW'(2 * NumPoints);

    // Curve after reset, highest point first.
    localparam logic [MvW-1:0]  ResetMv  [NumPoints] = '{16'd2950, 16'd2900, 16'd2550, 16'd1800};
    localparam logic [LvlW-1:0] ResetLvl [NumPoints] = '{14'd10000, 14'd4500, 14'd1500, 14'd0};

    // One curve point.
    typedef struct packed {
        logic [MvW-1:0]  mv;
        logic [LvlW-1:0] level;
    } plvm_point_t;

    // Segment chosen by the front stage.
    typedef struct packed {
        logic [LvlW-1:0] base;
        logic            neg;
        logic [LvlW-1:0] absd;
        logic [MvW-1:0]  dv;
        logic [MvW-1:0]  dm;
    } plvm_seg_t;

    // Record handed from one division cell to the next.
    typedef struct packed {
        logic [MvW-1:0]  rem;
        logic [LvlW-1:0] low;
        logic [LvlW-1:0] quo;
        logic [MvW-1:0]  dm;
        logic [LvlW-1:0] base;
        logic            neg;
    } plvm_div_t;

endpackage

@@ hw/rtl/plvm_front.sv @@
// Front end of the level mapper: segment search over the curve and the
// slope product. Two registered stages with their own valid/ready.
// Depends on plvm_pkg.
`timescale 1ns / 1ps

module plvm_front
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  plvm_pkg::plvm_point_t [plvm_pkg::NumPoints-1:0] curve,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [plvm_pkg::MvW-1:0]                     in_mv,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output plvm_pkg::plvm_div_t                          out_data
);

    logic                       a_valid_reg;
    plvm_pkg::plvm_seg_t        a_data_reg;
    plvm_pkg::plvm_seg_t        a_next;
    logic                       a_ready;
    logic                       b_valid_reg;
    plvm_pkg::plvm_div_t        b_data_reg;
    plvm_pkg::plvm_div_t        b_next;
    logic                       b_ready;
    logic [plvm_pkg::ProdW-1:0] prod;

    // Ready ripples back: a stage can load when it is empty or draining.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Walk down the curve while the voltage is below the point and the
    // point's level is not zero, then pick a flat level or a segment.
    always_comb
    begin
        logic                              going;
        logic [plvm_pkg::PointIdxW-1:0]    k;
        logic [plvm_pkg::PointIdxW-1:0]    km1;
        logic                              direct;
        plvm_pkg::plvm_point_t             lo_pt;
        plvm_pkg::plvm_point_t             hi_pt;

        going = 1'b1;
        k     = '0;
        for (int i = 0; i < plvm_pkg::NumPoints - 1; i++)
        begin
            if (going && (curve[i].level != '0) && (in_mv < curve[i].mv))
            begin
                k = plvm_pkg::PointIdxW'(i + 1);
            end
            else
            begin
                going = 1'b0;
            end
        end
        km1    = k - plvm_pkg::PointIdxW'(1);
        lo_pt  = curve[k];
        hi_pt  = curve[km1];
        direct = (k == '0) || (in_mv < lo_pt.mv);

        a_next.base = lo_pt.level;
        if (direct)
        begin
            // Flat result: a zero product and a full divisor give a zero quotient.
            a_next.neg  = 1'b0;
            a_next.absd = '0;
            a_next.dv   = '0;
            a_next.dm   = '1;
        end
        else
        begin
            a_next.neg  = hi_pt.level < lo_pt.level;
            a_next.absd = a_next.neg ? (lo_pt.level - hi_pt.level)
                                     : (hi_pt.level - lo_pt.level);
            a_next.dv   = in_mv - lo_pt.mv;
            a_next.dm   = hi_pt.mv - lo_pt.mv;
        end
    end

    // Product of level difference and voltage offset; the top bits start
    // the remainder, the low bits are shifted in by the division cells.
    assign prod = plvm_pkg::ProdW'(a_data_reg.absd) * plvm_pkg::ProdW'(a_data_reg.dv);

    always_comb
    begin
        b_next.rem  = prod[plvm_pkg::ProdW-1:plvm_pkg::LvlW];
        b_next.low  = prod[plvm_pkg::LvlW-1:0];
        b_next.quo  = '0;
        b_next.dm   = a_data_reg.dm;
        b_next.base = a_data_reg.base;
        b_next.neg  = a_data_reg.neg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_data_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    // The divisor is never zero once a transaction is in the stage.
    a_dm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_data_reg.dm != '0))
        else $error("segment stage holds a zero divisor");

    // The starting remainder is below the divisor, so the quotient fits.
    b_rem_below_dm: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_data_reg.rem < b_data_reg.dm))
        else $error("product stage remainder not below divisor");

endmodule

@@ hw/rtl/plvm_div_cell.sv @@
// One restoring division step of the level mapper's divider chain.
// Shifts one product bit into the remainder and produces one quotient bit.
// Depends on plvm_pkg.
`timescale 1ns / 1ps

module plvm_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  plvm_pkg::plvm_div_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output plvm_pkg::plvm_div_t out_data
);

    logic                      valid_reg;
    plvm_pkg::plvm_div_t       data_reg;
    plvm_pkg::plvm_div_t       data_next;
    logic [plvm_pkg::MvW:0]    trial;
    logic [plvm_pkg::MvW:0]    diff;
    logic                      fits;

    assign in_ready = !valid_reg || out_ready;

    // Trial subtraction of the divisor from the shifted remainder.
    assign trial = {in_data.rem, in_data.low[plvm_pkg::LvlW-1]};
    assign diff  = trial - {1'b0, in_data.dm};
    assign fits  = trial >= {1'b0, in_data.dm};

    always_comb
    begin
        data_next      = in_data;
        data_next.rem  = fits ? diff[plvm_pkg::MvW-1:0] : trial[plvm_pkg::MvW-1:0];
        data_next.low  = {in_data.low[plvm_pkg::LvlW-2:0], 1'b0};
        data_next.quo  = {in_data.quo[plvm_pkg::LvlW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The remainder stays below the divisor after every step.
    rem_below_dm: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem < data_reg.dm))
        else $error("division cell remainder not below divisor");

    // A stalled cell keeps its transaction.
    hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("division cell lost its transaction during a stall");

endmodule

@@ hw/rtl/piecewise_linear_level_mapper_core.sv @@
// Top level of the piecewise-linear level mapper: curve registers, front
// stages, the chain of division cells and the output register.
// Depends on plvm_pkg, plvm_front and plvm_div_cell.
//
//   Channel   Signals                                  Direction  Payload
//   s_axis    s_tvalid s_tready s_tdata[15:0]          in         batt_mv
//   m_axis    m_tvalid m_tready m_tdata[15:0]          out        level_pptt
//   config    cfg_valid cfg_ready cfg_index cfg_data   in         curve registers 0..7
//
// One transaction per cycle sustained while m_tready stays high; the stages are the
// segment stage, product stage, 14 division cells and output register.
// The divider chain, one quotient bit per cell, sets the depth.
// Reset clears all valid bits and loads the default curve; cfg_ready is always high.
// Each stage loads when empty or draining, so bubbles fill up during output stalls.
`timescale 1ns / 1ps

module piecewise_linear_level_mapper_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream: [15:0] batt_mv.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [plvm_pkg::InDataW-1:0]    s_tdata,
    // Output stream: [13:0] level_pptt, [15:14] zero.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [plvm_pkg::OutDataW-1:0]   m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plvm_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [plvm_pkg::CfgDataW-1:0]   cfg_data
);

    plvm_pkg::plvm_point_t [plvm_pkg::NumPoints-1:0] curve_reg;
    logic [plvm_pkg::PointIdxW-1:0]                  cfg_point;

    logic                 chain_valid [plvm_pkg::DivSteps+1];
    logic                 chain_ready [plvm_pkg::DivSteps+1];
    plvm_pkg::plvm_div_t  chain_data  [plvm_pkg::DivSteps+1];

    logic                            out_valid_reg;
    logic [plvm_pkg::LvlW-1:0]       out_level_reg;
    logic [plvm_pkg::LvlW-1:0]       out_level_next;
    logic                            last_ready;
    plvm_pkg::plvm_div_t             last_data;

    // Curve registers: even index is a voltage, odd index a level.
    assign cfg_ready = 1'b1;
    assign cfg_point = cfg_index[plvm_pkg::PointIdxW:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < plvm_pkg::NumPoints; i++)
            begin
                curve_reg[i].mv    <= plvm_pkg::ResetMv[i];
                curve_reg[i].level <= plvm_pkg::ResetLvl[i];
            end
        end
        else if (cfg_valid && (cfg_index < plvm_pkg::CfgRegCount))
        begin
            if (cfg_index[0])
            begin
                curve_reg[cfg_point].level <= cfg_data[plvm_pkg::LvlW-1:0];
            end
            else
            begin
                curve_reg[cfg_point].mv <= cfg_data[plvm_pkg::MvW-1:0];
            end
        end
    end

    // Segment search and slope product.
    plvm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .curve     (curve_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mv     (s_tdata[plvm_pkg::MvW-1:0]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // Chain of division cells, one quotient bit each.
    for (genvar g = 0; g < plvm_pkg::DivSteps; g++)
    begin : g_cell
        plvm_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // Output register: apply the signed quotient to the lower point's level.
    assign last_data      = chain_data[plvm_pkg::DivSteps];
    assign last_ready     = !out_valid_reg || m_tready;
    assign chain_ready[plvm_pkg::DivSteps] = last_ready;
    assign out_level_next = last_data.neg ? (last_data.base - last_data.quo)
                                          : (last_data.base + last_data.quo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (last_ready)
        begin
            out_valid_reg <= chain_valid[plvm_pkg::DivSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_ready && chain_valid[plvm_pkg::DivSteps])
        begin
            out_level_reg <= out_level_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = plvm_pkg::OutDataW'(out_level_reg);

    // With the output register empty, every stage can load, so input is open.
    ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the output register is empty");

    // A result leaving the chain takes the output register when it is free.
    chain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[plvm_pkg::DivSteps] && last_ready) |=> out_valid_reg)
        else $error("result from the divider chain was dropped");

    // The padding bits of the output word stay zero.
    pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[plvm_pkg::OutDataW-1:plvm_pkg::LvlW] == '0))
        else $error("output padding bits are not zero");

endmodule
